FILE: design/pwook_pkg.sv
// Shared types and constants for the pulse-width OOK frame encoder.
`timescale 1ns / 1ps
`default_nettype none

package pwook_pkg;

    localparam int unsigned TIME_W      = 16;
    localparam int unsigned COUNT_W     = 6;
    localparam int unsigned WORD_W      = 64;
    localparam int unsigned APB_ADDR_W  = 5;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned S_TDATA_W   = 64;
    localparam int unsigned M_TDATA_W   = 40;

    localparam logic [TIME_W-1:0]  SYNC_LEAD_RST  = 16'd35;
    localparam logic [TIME_W-1:0]  SYNC_TRAIL_RST = 16'd1085;
    localparam logic [TIME_W-1:0]  ZERO_LEAD_RST  = 16'd35;
    localparam logic [TIME_W-1:0]  ZERO_TRAIL_RST = 16'd105;
    localparam logic [TIME_W-1:0]  ONE_LEAD_RST   = 16'd105;
    localparam logic [TIME_W-1:0]  ONE_TRAIL_RST  = 16'd35;
    localparam logic [COUNT_W-1:0] BIT_COUNT_RST  = 6'd24;

    // Register index, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_SYNC_LEAD  = 3'd0,
        REG_SYNC_TRAIL = 3'd1,
        REG_ZERO_LEAD  = 3'd2,
        REG_ZERO_TRAIL = 3'd3,
        REG_ONE_LEAD   = 3'd4,
        REG_ONE_TRAIL  = 3'd5,
        REG_BIT_COUNT  = 3'd6,
        REG_INVERT     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0]  sync_lead_time;
        logic [TIME_W-1:0]  sync_trail_time;
        logic [TIME_W-1:0]  zero_lead_time;
        logic [TIME_W-1:0]  zero_trail_time;
        logic [TIME_W-1:0]  one_lead_time;
        logic [TIME_W-1:0]  one_trail_time;
        logic [COUNT_W-1:0] bit_count;
        logic               invert_levels;
    } cfg_t;

    typedef struct packed {
        logic              lead_level;
        logic [TIME_W-1:0] lead_time;
        logic [TIME_W-1:0] trail_time;
        logic              is_sync;
        logic              bit_value;
        logic              last_pulse;
    } pulse_t;

endpackage

`default_nettype wire

FILE: design/pwook_regs.sv
// APB configuration registers of the pulse-width OOK frame encoder.
`timescale 1ns / 1ps
`default_nettype none

module pwook_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [pwook_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [pwook_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [pwook_pkg::APB_DATA_W-1:0]   prdata,
    output pwook_pkg::cfg_t                         cfg
);
    import pwook_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[4:2]);
    assign wr_en = psel & penable & pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_SYNC_LEAD:  cfg_next.sync_lead_time  = pwdata[TIME_W-1:0];
                REG_SYNC_TRAIL: cfg_next.sync_trail_time = pwdata[TIME_W-1:0];
                REG_ZERO_LEAD:  cfg_next.zero_lead_time  = pwdata[TIME_W-1:0];
                REG_ZERO_TRAIL: cfg_next.zero_trail_time = pwdata[TIME_W-1:0];
                REG_ONE_LEAD:   cfg_next.one_lead_time   = pwdata[TIME_W-1:0];
                REG_ONE_TRAIL:  cfg_next.one_trail_time  = pwdata[TIME_W-1:0];
                REG_BIT_COUNT:  cfg_next.bit_count       = pwdata[COUNT_W-1:0];
                REG_INVERT:     cfg_next.invert_levels   = pwdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_lead_time  <= SYNC_LEAD_RST;
            cfg_reg.sync_trail_time <= SYNC_TRAIL_RST;
            cfg_reg.zero_lead_time  <= ZERO_LEAD_RST;
            cfg_reg.zero_trail_time <= ZERO_TRAIL_RST;
            cfg_reg.one_lead_time   <= ONE_LEAD_RST;
            cfg_reg.one_trail_time  <= ONE_TRAIL_RST;
            cfg_reg.bit_count       <= BIT_COUNT_RST;
            cfg_reg.invert_levels   <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (idx)
            REG_SYNC_LEAD:  prdata = APB_DATA_W'(cfg_reg.sync_lead_time);
            REG_SYNC_TRAIL: prdata = APB_DATA_W'(cfg_reg.sync_trail_time);
            REG_ZERO_LEAD:  prdata = APB_DATA_W'(cfg_reg.zero_lead_time);
            REG_ZERO_TRAIL: prdata = APB_DATA_W'(cfg_reg.zero_trail_time);
            REG_ONE_LEAD:   prdata = APB_DATA_W'(cfg_reg.one_lead_time);
            REG_ONE_TRAIL:  prdata = APB_DATA_W'(cfg_reg.one_trail_time);
            REG_BIT_COUNT:  prdata = APB_DATA_W'(cfg_reg.bit_count);
            REG_INVERT:     prdata = APB_DATA_W'(cfg_reg.invert_levels);
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: design/pwook_seq.sv
// Frame sequencer: bit counter and bit selector that walk one word into pulses.
`timescale 1ns / 1ps
`default_nettype none

module pwook_seq #(
    parameter int unsigned MAX_BITS = 63
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  pwook_pkg::cfg_t                    cfg,
    input  wire logic                          start,
    input  wire logic [pwook_pkg::WORD_W-1:0]  word,
    output logic                               idle,
    output logic                               pulse_valid,
    input  wire logic                          pulse_take,
    output pwook_pkg::pulse_t                  pulse
);
    import pwook_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_BITS + 1);
    localparam int unsigned IDX_W = $clog2(MAX_BITS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SYNC = 3'b010,
        ST_BITS = 3'b100
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [MAX_BITS-1:0]  data_reg;
    logic [CNT_W-1:0]     n_sat;
    logic [CNT_W-1:0]     cnt_dec;
    logic [IDX_W-1:0]     bit_idx;
    logic                 cur_bit;

    // Clamp the programmed count to what the data register can hold.
    assign n_sat = (cfg.bit_count > COUNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS)
                                                       : CNT_W'(cfg.bit_count);

    // Shared unit: one decrement both advances the count and picks the bit.
    assign cnt_dec = cnt_reg - CNT_W'(1);
    assign bit_idx = cnt_dec[IDX_W-1:0];
    assign cur_bit = data_reg[bit_idx];

    assign idle        = (state_reg == ST_IDLE);
    assign pulse_valid = !idle;

    always_comb begin
        pulse.lead_level = ~cfg.invert_levels;
        if (state_reg == ST_SYNC) begin
            pulse.lead_time  = cfg.sync_lead_time;
            pulse.trail_time = cfg.sync_trail_time;
            pulse.is_sync    = 1'b1;
            pulse.bit_value  = 1'b0;
            pulse.last_pulse = (cnt_reg == '0);
        end else begin
            pulse.lead_time  = cur_bit ? cfg.one_lead_time  : cfg.zero_lead_time;
            pulse.trail_time = cur_bit ? cfg.one_trail_time : cfg.zero_trail_time;
            pulse.is_sync    = 1'b0;
            pulse.bit_value  = cur_bit;
            pulse.last_pulse = (cnt_dec == '0);
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_SYNC;
                    cnt_next   = n_sat;
                end
            end
            ST_SYNC: begin
                if (pulse_take) begin
                    state_next = (cnt_reg == '0) ? ST_IDLE : ST_BITS;
                end
            end
            ST_BITS: begin
                if (pulse_take) begin
                    cnt_next   = cnt_dec;
                    state_next = (cnt_dec == '0) ? ST_IDLE : ST_BITS;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (idle && start) begin
            data_reg <= word[MAX_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: design/pulse_width_ook_encoder_core.sv
// Top level of the pulse-width OOK frame encoder.
//
// Usage:
//   Configure pulse durations, bit count and level inversion over the APB
//   port (register i at byte address 4*i) while the block is idle.
//   Present one packet word on the s_ stream; each accepted request yields a
//   frame of pulses on the m_ stream: first the sync pulse (m_tuser high),
//   then one pulse per data bit, most significant of the low bit_count bits
//   first. m_tlast marks the final pulse of the frame.
// Timing:
//   After acceptance the sequencer enters its sync state, and the sync pulse
//   is loaded into the output register when that register is free; with the
//   receiver ready, one pulse leaves per cycle. The bit counter of the
//   sequencer emits one pulse per cycle while the output register is free.
//   s_tready is low while a frame is being walked.
// Reset and stall:
//   aresetn (synchronous, active low) restores the default timing registers,
//   drops any frame in flight and clears the output valid flag.
//   When m_tready is low, hold the current pulse; the sequencer waits.
`timescale 1ns / 1ps
`default_nettype none

module pulse_width_ook_encoder_core #(
    parameter int unsigned MAX_BITS = 63
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // APB configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [pwook_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [pwook_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [pwook_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                     pready,
    // Input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [pwook_pkg::S_TDATA_W-1:0]     s_tdata,   // [63:0] data_word
    // Pulse stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [0] lead_level, [16:1] lead_time, [32:17] trail_time, [33] bit_value,
    // [39:34] zero
    output logic      [pwook_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                     m_tuser,   // [0] is_sync
    output logic                                     m_tlast
);
    import pwook_pkg::*;

    cfg_t   cfg;
    pulse_t pulse;
    pulse_t pulse_reg;
    logic   seq_idle;
    logic   pulse_valid;
    logic   out_free;
    logic   pulse_take;
    logic   m_valid_reg;
    logic   m_valid_next;

    assign pready = 1'b1;

    pwook_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Accept a new word whenever the sequencer is idle, even with the
    // previous frame's last pulse still waiting in the output register.
    assign s_tready = seq_idle;

    pwook_seq #(
        .MAX_BITS (MAX_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .start       (s_tvalid),
        .word        (s_tdata),
        .idle        (seq_idle),
        .pulse_valid (pulse_valid),
        .pulse_take  (pulse_take),
        .pulse       (pulse)
    );

    // Output register: advance when empty or when the receiver takes it.
    assign out_free   = !m_valid_reg || m_tready;
    assign pulse_take = pulse_valid && out_free;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = pulse_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pulse_take) begin
            pulse_reg <= pulse;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, pulse_reg.bit_value, pulse_reg.trail_time,
                       pulse_reg.lead_time, pulse_reg.lead_level};
    assign m_tuser  = pulse_reg.is_sync;
    assign m_tlast  = pulse_reg.last_pulse;

endmodule

`default_nettype wire

FILE: tb/sv/pwook_frame_checker.sv
// Frame checker: shadows the timing registers, predicts each pulse train and scores the outputs.
`timescale 1ns / 1ps

module pwook_frame_checker
    import pwook_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    output int unsigned           mismatch_count,
    output int unsigned           pulses_pending
);

    localparam int unsigned REPORT_MAX = 10;

    cfg_t        timing;
    pulse_t      frame_pulses[$];
    int unsigned bad_pulses = 0;
    int unsigned pending_r  = 0;

    assign mismatch_count = bad_pulses;
    assign pulses_pending = pending_r;

    // Expand one data word into its sync pulse and one pulse per sent bit.
    // bit_count is six bits wide, so it never exceeds the 63-bit ceiling.
    function automatic void encode_frame(input logic [WORD_W-1:0] word);
        pulse_t p;
        p.lead_level = ~timing.invert_levels;
        p.lead_time  = timing.sync_lead_time;
        p.trail_time = timing.sync_trail_time;
        p.is_sync    = 1'b1;
        p.bit_value  = 1'b0;
        p.last_pulse = (timing.bit_count == '0);
        frame_pulses.push_back(p);
        for (int i = int'(timing.bit_count) - 1; i >= 0; i--) begin
            p.is_sync    = 1'b0;
            p.bit_value  = word[i];
            p.lead_time  = word[i] ? timing.one_lead_time  : timing.zero_lead_time;
            p.trail_time = word[i] ? timing.one_trail_time : timing.zero_trail_time;
            p.last_pulse = (i == 0);
            frame_pulses.push_back(p);
        end
    endfunction

    function automatic void flag_pulse(input string why, input pulse_t want, input pulse_t got);
        bad_pulses++;
        if (bad_pulses <= REPORT_MAX) begin
            $display("[%0t] pulse mismatch (%s)", $realtime, why);
            $display("    expected lvl=%0b lead=%0d trail=%0d sync=%0b bit=%0b last=%0b",
                     want.lead_level, want.lead_time, want.trail_time,
                     want.is_sync, want.bit_value, want.last_pulse);
            $display("    actual   lvl=%0b lead=%0d trail=%0d sync=%0b bit=%0b last=%0b",
                     got.lead_level, got.lead_time, got.trail_time,
                     got.is_sync, got.bit_value, got.last_pulse);
        end
    endfunction

    always @(posedge aclk) begin
        pulse_t seen;
        pulse_t want;
        if (!aresetn) begin
            timing.sync_lead_time  = SYNC_LEAD_RST;
            timing.sync_trail_time = SYNC_TRAIL_RST;
            timing.zero_lead_time  = ZERO_LEAD_RST;
            timing.zero_trail_time = ZERO_TRAIL_RST;
            timing.one_lead_time   = ONE_LEAD_RST;
            timing.one_trail_time  = ONE_TRAIL_RST;
            timing.bit_count       = BIT_COUNT_RST;
            timing.invert_levels   = 1'b0;
            frame_pulses.delete();
        end else begin
            // Mask each write to its register width.
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_SYNC_LEAD:  timing.sync_lead_time  = pwdata[TIME_W-1:0];
                    REG_SYNC_TRAIL: timing.sync_trail_time = pwdata[TIME_W-1:0];
                    REG_ZERO_LEAD:  timing.zero_lead_time  = pwdata[TIME_W-1:0];
                    REG_ZERO_TRAIL: timing.zero_trail_time = pwdata[TIME_W-1:0];
                    REG_ONE_LEAD:   timing.one_lead_time   = pwdata[TIME_W-1:0];
                    REG_ONE_TRAIL:  timing.one_trail_time  = pwdata[TIME_W-1:0];
                    REG_BIT_COUNT:  timing.bit_count       = pwdata[COUNT_W-1:0];
                    REG_INVERT:     timing.invert_levels   = pwdata[0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                encode_frame(s_tdata);

            if (m_tvalid && m_tready) begin
                seen.lead_level = m_tdata[0];
                seen.lead_time  = m_tdata[16:1];
                seen.trail_time = m_tdata[32:17];
                seen.bit_value  = m_tdata[33];
                seen.is_sync    = m_tuser;
                seen.last_pulse = m_tlast;
                if (frame_pulses.size() == 0) begin
                    want = '0;
                    flag_pulse("no pulse expected", want, seen);
                end else begin
                    want = frame_pulses.pop_front();
                    if (seen !== want)
                        flag_pulse("field differs", want, seen);
                    else if (m_tdata[39:34] !== '0)
                        flag_pulse("pad bits set", want, seen);
                end
            end
        end
        pending_r <= frame_pulses.size();
    end

endmodule

FILE: tb/sv/tb_pulse_width_ook_encoder_core.sv
// Testbench top: drives data words and register writes into the OOK encoder and gives the verdict.
`timescale 1ns / 1ps

module tb_pulse_width_ook_encoder_core;
    import pwook_pkg::*;

    localparam int unsigned WORD_TARGET = 91;     // random data words after the directed part
    localparam int unsigned SETTLE      = 8;      // settling pad after the last pulse; pad generously
    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_PERIODIC, RX_SLOW} rx_mode_e;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    int unsigned           mismatch_count;
    int unsigned           pulses_pending;

    logic [WORD_W-1:0]     word_q[$];      // data words waiting to be sent
    rx_mode_e              rx_mode = RX_STREAM;
    logic [15:0]           rx_tick = '0;

    pulse_width_ook_encoder_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [63:0] data_word
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [0] lead_level, [16:1] lead_time, [32:17] trail_time,
                                // [33] bit_value, [39:34] zero
        .m_tuser  (m_tuser),    // [0] is_sync
        .m_tlast  (m_tlast)
    );

    pwook_frame_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pulses_pending (pulses_pending)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Receiver backpressure: pick a new stall pattern whenever the low byte of rx_tick wraps, so that
    // stretches of full-rate draining alternate with random, periodic and heavy stalls.
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 16'd1;
        if (rx_tick[7:0] == 8'd0)
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
        case (rx_mode)
            RX_STREAM:   m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 9) < 6);
            RX_PERIODIC: m_tready <= ((rx_tick % 5) < 3);
            default:     m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Hard stop in case the block hangs.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Regression FAIL");
        $finish;
    end

    // Put one register write on the bus: setup cycle, then access cycle.
    // Leave psel high so back-to-back writes never toggle it within one step;
    // fill the bits above the register width with junk to exercise masking.
    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value,
                             input logic [31:0] keep);
        logic [31:0] junk;
        junk    = $urandom_range(0, 1) ? $urandom : 32'd0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (value & keep) | (junk & ~keep);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
    endtask

    // Rewrite every timing register, then release the bus.
    task automatic program_timing(input logic [15:0] sync_lead, input logic [15:0] sync_trail,
                                  input logic [15:0] zero_lead, input logic [15:0] zero_trail,
                                  input logic [15:0] one_lead,  input logic [15:0] one_trail,
                                  input logic [5:0] nbits, input logic invert);
        apb_write(REG_SYNC_LEAD,  32'(sync_lead),  32'h0000_FFFF);
        apb_write(REG_SYNC_TRAIL, 32'(sync_trail), 32'h0000_FFFF);
        apb_write(REG_ZERO_LEAD,  32'(zero_lead),  32'h0000_FFFF);
        apb_write(REG_ZERO_TRAIL, 32'(zero_trail), 32'h0000_FFFF);
        apb_write(REG_ONE_LEAD,   32'(one_lead),   32'h0000_FFFF);
        apb_write(REG_ONE_TRAIL,  32'(one_trail),  32'h0000_FFFF);
        apb_write(REG_BIT_COUNT,  32'(nbits),      32'h0000_003F);
        apb_write(REG_INVERT,     32'(invert),     32'h0000_0001);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Send every queued word. Work in bursts of random length; between bursts
    // drop tvalid for a random gap. Hold tvalid high across words in a burst.
    task automatic drain_words();
        int burst;
        int gap;
        burst = 0;
        while (word_q.size() > 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 8);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            s_tvalid <= 1'b1;
            s_tdata  <= word_q.pop_front();
            do @(posedge aclk); while (!s_tready);
            burst--;
        end
        s_tvalid <= 1'b0;
    endtask

    // Wait until every predicted pulse has left the block, then let it settle.
    task automatic wait_idle();
        @(posedge aclk);
        while (pulses_pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Durations: lean on the extremes, otherwise anything.
    function automatic logic [15:0] pick_time();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Bit count: mostly short frames, with a few empty and full-length ones.
    function automatic logic [5:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return 6'd0;
            1:       return 6'd63;
            2:       return 6'($urandom_range(0, 63));
            default: return 6'($urandom_range(1, 12));
        endcase
    endfunction

    // Payload: mostly full random words, sometimes sparse or dense patterns.
    function automatic logic [63:0] pick_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return w & {$urandom, $urandom} & {$urandom, $urandom};
            1:       return w | {$urandom, $urandom} | {$urandom, $urandom};
            default: return w;
        endcase
    endfunction

    initial begin
        int sent;
        int chunk;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset timing, 24-bit frames: zero, all ones, alternating, bits above the frame,
        // and the first and last sent bits alone.
        word_q.push_back(64'h0000_0000_0000_0000);
        word_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        word_q.push_back(64'h5555_5555_5555_5555);
        word_q.push_back(64'h0000_0000_00A5_5A3C);
        word_q.push_back(64'hFFFF_FFFF_FF00_0000);
        word_q.push_back(64'h0000_0000_0080_0001);
        drain_words();
        wait_idle();

        // Empty frame: only the sync pulse, marked last; inverted levels, extreme times.
        program_timing(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 6'd0, 1'b1);
        word_q.push_back(64'h0000_0000_0000_0000);
        word_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        drain_words();
        wait_idle();

        // Longest frame: 63 bits, bit 63 never sent.
        program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 1'b0);
        word_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        word_q.push_back(64'h0000_0000_0000_0000);
        word_q.push_back(64'h8000_0000_0000_0000);
        word_q.push_back(64'h4000_0000_0000_0001);
        word_q.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        drain_words();
        wait_idle();

        // Single-bit frames with zero durations.
        program_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd1, 1'b1);
        word_q.push_back(64'h0000_0000_0000_0000);
        word_q.push_back(64'h0000_0000_0000_0001);
        word_q.push_back(64'hFFFF_FFFF_FFFF_FFFE);
        drain_words();
        wait_idle();

        // Mid-size frame with distinct durations per field.
        program_timing(16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 6'd32, 1'b0);
        repeat (3) word_q.push_back(pick_word());
        drain_words();
        wait_idle();

        // Random part: a fresh register set per phase, drained to idle before the next.
        sent = 0;
        while (sent < WORD_TARGET) begin
            program_timing(pick_time(), pick_time(), pick_time(), pick_time(),
                           pick_time(), pick_time(), pick_count(), 1'($urandom_range(0, 1)));
            chunk = $urandom_range(10, 16);
            if (chunk > WORD_TARGET - sent)
                chunk = WORD_TARGET - sent;
            repeat (chunk) word_q.push_back(pick_word());
            sent += chunk;
            drain_words();
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
